// ===== design/young_tableau_priority_queue_defines.svh =====
// ---------------------------------------------------------------------------
// Young tableau priority queue assertion macros
// Shared concurrent assertion forms for the queue's RTL.
// ---------------------------------------------------------------------------
`ifndef YOUNG_TABLEAU_PRIORITY_QUEUE_DEFINES_SVH
`define YOUNG_TABLEAU_PRIORITY_QUEUE_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define YTPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define YTPQ_IMPLY(lbl, cond, cons, msg) \
  `YTPQ_ASSERT(lbl, (cond) |-> (cons), msg)

`endif

// ===== design/ytpq_pkg.sv =====
// ---------------------------------------------------------------------------
// Young tableau priority queue package
// Key sentinel, mode and status codes, and the cell write bundle.
// ---------------------------------------------------------------------------
`default_nettype none
package ytpq_pkg;
  localparam logic signed [31:0] EMPTY_KEY = 32'sh7FFF_FFFF;

  typedef enum logic [1:0] {
    MODE_INSERT  = 2'd0,
    MODE_EXTRACT = 2'd1,
    MODE_FIND    = 2'd2,
    MODE_NONE    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RSVD  = 2'd3
  } status_t;

  typedef struct packed {
    logic               we;
    logic signed [31:0] d;
  } cell_wr_t;
endpackage
`default_nettype wire

// ===== design/ytpq_cell.sv =====
// ---------------------------------------------------------------------------
// Young tableau cell
// One key register of the grid; reset loads the empty sentinel.
// ---------------------------------------------------------------------------
`default_nettype none
module ytpq_cell (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  ytpq_pkg::cell_wr_t     wr,
  output logic signed [31:0]     q
);
  import ytpq_pkg::*;

  logic signed [31:0] key_r;
  logic signed [31:0] key_nxt;

  always_comb begin
    key_nxt = wr.we ? wr.d : key_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= EMPTY_KEY;
    end else begin
      key_r <= key_nxt;
    end
  end

  assign q = key_r;
endmodule
`default_nettype wire

// ===== design/young_tableau_priority_queue.sv =====
// Walk: insert and extract move the walking key by one compare-swap per
//   cycle; find moves one staircase step per cycle; full, empty and
//   unused-mode transactions go straight from idle to the finish state.
// Throughput: one transaction at a time; the next one is taken once the
//   sequencer is back in idle.
// Reset: synchronous active low; every cell loads the empty sentinel at once.
// ---------------------------------------------------------------------------
// Young tableau priority queue
// Grid of key cells with a sequencer that walks insert, extract-min and
// staircase find one cell step per cycle.
// ---------------------------------------------------------------------------
`default_nettype none
`include "young_tableau_priority_queue_defines.svh"
module young_tableau_priority_queue #(
  parameter int ROWS = 8,
  parameter int COLS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // [1:0] mode, [33:2] key, [39:34] zero
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata   // [31:0] min_key, [32] found, [34:33] status
);
  import ytpq_pkg::*;

  localparam int NCELL = ROWS * COLS;
  localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW    = (COLS > 1) ? $clog2(COLS) : 1;
  localparam logic [RW-1:0] RLAST = RW'(ROWS - 1);
  localparam logic [CW-1:0] CLAST = CW'(COLS - 1);

  typedef enum logic [2:0] {S_IDLE, S_INS, S_EXT, S_FND, S_FIN} state_t;

  state_t              state_r, state_nxt;
  logic [RW-1:0]       r_r, r_nxt;
  logic [CW-1:0]       c_r, c_nxt;
  logic signed [31:0]  cur_r, cur_nxt;      // walking key or search key
  logic signed [31:0]  res_min_r, res_min_nxt;
  logic                res_fnd_r, res_fnd_nxt;
  status_t             res_st_r, res_st_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [39:0]         out_data_r, out_data_nxt;

  logic signed [31:0]  cell_q [NCELL];
  cell_wr_t            cell_wr [NCELL];

  // Per-cell decisions, each bit raised only by the cell the walker sits on.
  wire [NCELL-1:0]     ins_a_v, ins_b_v, ext_a_v, ext_b_v, eq_v, gt_v;

  logic                ld_last, ld_first;   // load bottom-right / top-left

  mode_t               in_mode;
  logic signed [31:0]  in_key;
  logic                in_fire;

  logic                pk_a, pk_b;          // pick up/down, pick left/right

  assign in_mode   = mode_t'(in_tdata[1:0]);
  assign in_key    = $signed(in_tdata[33:2]);
  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    state_nxt     = state_r;
    r_nxt         = r_r;
    c_nxt         = c_r;
    cur_nxt       = cur_r;
    res_min_nxt   = res_min_r;
    res_fnd_nxt   = res_fnd_r;
    res_st_nxt    = res_st_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    ld_last  = 1'b0;
    ld_first = 1'b0;
    pk_a = 1'b0; pk_b = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          res_min_nxt = EMPTY_KEY;
          res_fnd_nxt = 1'b0;
          res_st_nxt  = ST_OK;
          cur_nxt     = in_key;
          state_nxt   = S_FIN;
          case (in_mode)
            MODE_INSERT: begin
              if (cell_q[NCELL-1] != EMPTY_KEY) begin
                res_st_nxt = ST_FULL;
              end else if (in_key != EMPTY_KEY) begin
                // Drop the key into the bottom-right cell, then float it.
                ld_last = 1'b1;
                r_nxt = RLAST; c_nxt = CLAST;
                state_nxt = S_INS;
              end
            end
            MODE_EXTRACT: begin
              if (cell_q[0] == EMPTY_KEY) begin
                res_st_nxt = ST_EMPTY;
              end else begin
                res_min_nxt = cell_q[0];
                ld_first = 1'b1;
                cur_nxt = EMPTY_KEY;
                r_nxt = '0; c_nxt = '0;
                state_nxt = S_EXT;
              end
            end
            MODE_FIND: begin
              if (in_key != EMPTY_KEY) begin
                r_nxt = RLAST; c_nxt = '0;
                state_nxt = S_FND;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_INS: begin
        // Swap toward the larger neighbor; left wins if above the chosen best.
        pk_a = |ins_a_v;
        pk_b = |ins_b_v;
        if (pk_b) begin
          c_nxt = c_r - CW'(1);
        end else if (pk_a) begin
          r_nxt = r_r - RW'(1);
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_EXT: begin
        // Sink the sentinel toward the smaller neighbor.
        pk_a = |ext_a_v;
        pk_b = |ext_b_v;
        if (pk_b) begin
          c_nxt = c_r + CW'(1);
        end else if (pk_a) begin
          r_nxt = r_r + RW'(1);
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FND: begin
        if (|eq_v) begin
          res_fnd_nxt = 1'b1;
          state_nxt = S_FIN;
        end else if (|gt_v) begin
          if (r_r == '0) state_nxt = S_FIN;
          else r_nxt = r_r - RW'(1);
        end else begin
          if (c_r == CLAST) state_nxt = S_FIN;
          else c_nxt = c_r + CW'(1);
        end
      end
      S_FIN: begin
        // Hand the result over once the output register is free.
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {5'd0, res_st_r, res_fnd_r, res_min_r};
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    r_r        <= r_nxt;
    c_r        <= c_nxt;
    cur_r      <= cur_nxt;
    res_min_r  <= res_min_nxt;
    res_fnd_r  <= res_fnd_nxt;
    res_st_r   <= res_st_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Each cell compares against its fixed neighbors and swaps with them.
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    localparam int RI = i / COLS;
    localparam int CI = i % COLS;
    localparam bit HAS_UP = (RI > 0);
    localparam bit HAS_DN = (RI < ROWS - 1);
    localparam bit HAS_LF = (CI > 0);
    localparam bit HAS_RT = (CI < COLS - 1);
    localparam int UI = HAS_UP ? i - COLS : i;
    localparam int DI = HAS_DN ? i + COLS : i;
    localparam int LI = HAS_LF ? i - 1 : i;
    localparam int TI = HAS_RT ? i + 1 : i;

    logic act;

    assign act = (r_r == RW'(RI)) && (c_r == CW'(CI));
    assign ins_a_v[i] = act && HAS_UP && (cell_q[UI] > cur_r);
    assign ins_b_v[i] = act && HAS_LF &&
                        (cell_q[LI] > (ins_a_v[i] ? cell_q[UI] : cur_r));
    assign ext_a_v[i] = act && HAS_DN && (cell_q[DI] < EMPTY_KEY);
    assign ext_b_v[i] = act && HAS_RT &&
                        (cell_q[TI] < (ext_a_v[i] ? cell_q[DI] : EMPTY_KEY));
    assign eq_v[i] = act && (cell_q[i] == cur_r);
    assign gt_v[i] = act && (cell_q[i] > cur_r);

    always_comb begin
      cell_wr[i].we = 1'b0;
      cell_wr[i].d  = cur_r;
      if (ld_last && (i == NCELL - 1)) begin
        cell_wr[i].we = 1'b1;
        cell_wr[i].d  = in_key;
      end else if (ld_first && (i == 0)) begin
        cell_wr[i].we = 1'b1;
        cell_wr[i].d  = EMPTY_KEY;
      end else if (state_r == S_INS) begin
        if (ins_b_v[i]) begin
          cell_wr[i].we = 1'b1;
          cell_wr[i].d  = cell_q[LI];
        end else if (ins_a_v[i]) begin
          cell_wr[i].we = 1'b1;
          cell_wr[i].d  = cell_q[UI];
        end else if (HAS_RT && ins_b_v[TI]) begin
          cell_wr[i].we = 1'b1;
          cell_wr[i].d  = cur_r;
        end else if (HAS_DN && ins_a_v[DI] && !ins_b_v[DI]) begin
          cell_wr[i].we = 1'b1;
          cell_wr[i].d  = cur_r;
        end
      end else if (state_r == S_EXT) begin
        if (ext_b_v[i]) begin
          cell_wr[i].we = 1'b1;
          cell_wr[i].d  = cell_q[TI];
        end else if (ext_a_v[i]) begin
          cell_wr[i].we = 1'b1;
          cell_wr[i].d  = cell_q[DI];
        end else if (HAS_LF && ext_b_v[LI]) begin
          cell_wr[i].we = 1'b1;
          cell_wr[i].d  = EMPTY_KEY;
        end else if (HAS_UP && ext_a_v[UI] && !ext_b_v[UI]) begin
          cell_wr[i].we = 1'b1;
          cell_wr[i].d  = EMPTY_KEY;
        end
      end
    end

    ytpq_cell u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .wr   (cell_wr[i]),
      .q    (cell_q[i])
    );
  end

  `YTPQ_IMPLY(a_idle_order, state_r == S_IDLE, cell_q[0] <= cell_q[1], "corner order broken")
  `YTPQ_IMPLY(a_fail_nofind, out_tvalid && out_tdata[34:33] != ST_OK, !out_tdata[32], "found on failure")
  `YTPQ_IMPLY(a_empty_min, out_tvalid && out_tdata[34:33] == ST_EMPTY, out_tdata[31:0] == EMPTY_KEY, "min on empty")
endmodule
`default_nettype wire
